// ----- rtl/aupt_pkg.sv -----
// Shared types, codes and defaults for the adaptive update policy table.
package aupt_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 256;
  localparam int unsigned DEF_MAX_FOUND   = 64;

  localparam int unsigned AVI_W      = 24;
  localparam int unsigned BETA_W     = 12;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_AVI  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA = 8'd1;

  localparam logic [AVI_W-1:0]  AVI_RESET  = 24'd1000;
  localparam logic [BETA_W-1:0] BETA_RESET = 12'd512;
  localparam logic [15:0]       RATIO_ONE  = 16'd256;
  localparam logic [15:0]       RATIO_MAX  = 16'hFFFF;

  // Operation codes carried in the func field.
  localparam logic [3:0] FUNC_INIT      = 4'd0;
  localparam logic [3:0] FUNC_ACC_INC   = 4'd1;
  localparam logic [3:0] FUNC_ACC_CLR   = 4'd2;
  localparam logic [3:0] FUNC_UPD_INC   = 4'd3;
  localparam logic [3:0] FUNC_UPD_CLR   = 4'd4;
  localparam logic [3:0] FUNC_CLR_ALL   = 4'd5;
  localparam logic [3:0] FUNC_SCAN      = 4'd6;
  localparam logic [3:0] FUNC_SCHEDULE  = 4'd7;
  localparam logic [3:0] FUNC_RELAX     = 4'd8;
  localparam logic [3:0] FUNC_READ      = 4'd9;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [3:0]  func;
    logic [7:0]  index;
    logic [8:0]  scan_count;
    logic [6:0]  max_found;
    logic [47:0] now_ms;
    logic [8:0]  relax_fraction;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  found_index;
    logic        found_valid;
    logic        last;
    logic [31:0] access_count;
    logic [31:0] update_count;
    logic [31:0] flexible_interval;
    logic [47:0] next_update_time;
    logic [15:0] p_ext_ratio;
  } res_t;

  // One table row as it is stored.
  typedef struct packed {
    logic [31:0] acc;
    logic [31:0] upd;
    logic [31:0] flex;
    logic [47:0] due;
  } row_t;

endpackage

// ----- rtl/aupt_mem.sv -----
// Table row memory with per-row count valid bits so that a clear-all zeroes every count at once.
module aupt_mem #(
  parameter int unsigned DEPTH = aupt_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned AW    = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               we_i,
  input  logic [AW-1:0]      addr_i,
  input  aupt_pkg::row_t     wdata_i,
  input  logic               clr_cnt_i,
  output aupt_pkg::row_t     rdata_o
);

  aupt_pkg::row_t mem [DEPTH];
  aupt_pkg::row_t rd_q;
  logic [DEPTH-1:0] cnt_vld_q;
  logic             rd_cnt_vld_q;

  // Storage array: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rd_q <= mem[addr_i];
  end

  // Count valid bits: a clear-all drops them, a row write sets its own.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q    <= '0;
      rd_cnt_vld_q <= 1'b0;
    end else begin
      rd_cnt_vld_q <= cnt_vld_q[addr_i];
      if (clr_cnt_i) begin
        cnt_vld_q <= '0;
      end else if (we_i) begin
        cnt_vld_q[addr_i] <= 1'b1;
      end
    end
  end

  // Counts of rows not written since a clear-all read as zero.
  always_comb begin
    rdata_o.acc  = rd_cnt_vld_q ? rd_q.acc : 32'd0;
    rdata_o.upd  = rd_cnt_vld_q ? rd_q.upd : 32'd0;
    rdata_o.flex = rd_q.flex;
    rdata_o.due  = rd_q.due;
  end

endmodule

// ----- rtl/aupt_div10.sv -----
// Nibble-serial divide by ten, one quotient digit per cycle.
module aupt_div10 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [35:0] x_i,
  output logic        done_o,
  output logic [35:0] q_o
);

  localparam int unsigned NIBBLES = 9;

  logic [35:0] x_q;
  logic [3:0]  rem_q;
  logic [3:0]  cnt_q;
  logic        busy_q;
  logic [7:0]  v;
  logic [3:0]  qd;
  logic [7:0]  qd_x10;

  // One radix-16 long-division step; v stays below 160.
  always_comb begin
    v  = {rem_q, x_q[35:32]};
    qd = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (v >= 8'(k * 10)) begin
        qd = 4'(k);
      end
    end
    qd_x10 = {1'b0, qd, 3'b0} + {3'b0, qd, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      x_q    <= '0;
      q_o    <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        x_q    <= x_i;
        rem_q  <= '0;
        cnt_q  <= 4'(NIBBLES - 1);
      end else if (busy_q) begin
        x_q   <= {x_q[31:0], 4'd0};
        rem_q <= 4'(v - qd_x10);
        q_o   <= {q_o[31:0], qd};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 4'd1;
        end
      end
    end
  end

endmodule

// ----- rtl/aupt_ratio_div.sv -----
// Restoring divider for the mean ratio, one quotient bit per cycle, saturating.
module aupt_ratio_div #(
  parameter int unsigned SUM_W = 41,
  parameter int unsigned DIV_W = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] sum_i,
  input  logic [DIV_W-1:0] div_i,
  output logic             done_o,
  output logic [15:0]      ratio_o
);

  localparam int unsigned W = DIV_W + 17;

  logic [W-1:0] rem_q;
  logic [W-1:0] dsh_q;
  logic [15:0]  q_q;
  logic [4:0]   cnt_q;
  logic         busy_q;
  logic         ge;

  assign ge = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_o  <= 1'b0;
      ratio_o <= '0;
      rem_q   <= '0;
      dsh_q   <= '0;
      q_q     <= '0;
      cnt_q   <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        if (div_i == '0) begin
          ratio_o <= aupt_pkg::RATIO_MAX;
          done_o  <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          rem_q  <= W'(sum_i);
          dsh_q  <= {W'(div_i)} << 16;
          q_q    <= '0;
          cnt_q  <= 5'd16;
        end
      end else if (busy_q) begin
        if (cnt_q == 5'd16) begin
          // A quotient of 65536 or more saturates.
          if (ge) begin
            ratio_o <= aupt_pkg::RATIO_MAX;
            done_o  <= 1'b1;
            busy_q  <= 1'b0;
          end else begin
            dsh_q <= dsh_q >> 1;
            cnt_q <= 5'd15;
          end
        end else begin
          if (ge) begin
            rem_q <= rem_q - dsh_q;
          end
          q_q <= {q_q[14:0], ge};
          if (cnt_q == '0) begin
            ratio_o <= {q_q[14:0], ge};
            done_o  <= 1'b1;
            busy_q  <= 1'b0;
          end else begin
            dsh_q <= dsh_q >> 1;
            cnt_q <= cnt_q - 5'd1;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/adaptive_update_policy_table.sv -----
// Top level of the adaptive update policy table: sequencer, registers and units.
//
//  channel  | signals                                  | transfer
//  ---------+------------------------------------------+-------------------------------
//  request  | start_i, busy_o, req_i                   | start_i high while busy_o low
//  result   | res_valid_o, res_o                       | res_valid_o high, one cycle
//  config   | cfg_valid_i, cfg_ready_o, cfg_index_i,   | cfg_valid_i and cfg_ready_o
//           | cfg_data_i                               |
//
// After reset a clearing pass writes every row to its reset value, with busy_o high.
// Init runs the same pass and answers at its end. Clear-all and unused codes answer
// without leaving the idle state. Single-entry operations go through memory read,
// registered data and write back. A scan reads and examines one entry after another
// until the range end or the hit limit. A relax visits every row through the single
// memory port, sending each row whose access count is below its update count through
// the divide-by-ten unit while the target lasts, and then runs the ratio divider.
// Results cannot be stalled; each is shown for exactly one cycle.
module adaptive_update_policy_table #(
  parameter int unsigned TABLE_DEPTH = aupt_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned MAX_FOUND   = aupt_pkg::DEF_MAX_FOUND
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  aupt_pkg::req_t                      req_i,
  output logic                                res_valid_o,
  output aupt_pkg::res_t                      res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [aupt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [aupt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned SUM_W = 32 + CW;
  localparam int unsigned DIV_W = aupt_pkg::AVI_W + CW;
  localparam int unsigned PW    = 9 + CW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_SG_RD,
    ST_SG_EX,
    ST_SC_RD,
    ST_SC_EX,
    ST_SC_FIN,
    ST_RX_RD,
    ST_RX_EX,
    ST_RX_DV,
    ST_RX_MN
  } state_e;

  state_e                          state_q;
  aupt_pkg::req_t                  req_q;
  logic [aupt_pkg::AVI_W-1:0]      avi_q;
  logic [aupt_pkg::BETA_W-1:0]     beta_q;
  logic [31:0]                     init_flex_q;
  logic [15:0]                     mean_q;
  logic [CW-1:0]                   i_q;
  logic [CW-1:0]                   end_q;
  logic [CW-1:0]                   target_q;
  logic [6:0]                      maxf_q;
  logic [6:0]                      hits_q;
  logic                            pend_q;
  logic [7:0]                      pidx_q;
  logic [SUM_W-1:0]                sum_q;
  aupt_pkg::row_t                  row_q;
  logic                            clr_res_q;

  aupt_pkg::row_t                  rdata;
  aupt_pkg::row_t                  wdata;
  aupt_pkg::row_t                  sg_row;
  logic                            we;
  logic                            accept;
  logic                            clr_cnt;
  logic                            in_range;
  logic [9:0]                      scan_end;
  logic [6:0]                      maxf_eff;
  logic [PW-1:0]                   tgt_prod;
  logic [PW-1:0]                   tgt_raw;
  logic                            cand;
  logic                            d10_start;
  logic                            d10_done;
  logic [35:0]                     d10_q;
  logic [35:0]                     hi_bound;
  logic                            stretch_ok;
  logic                            rx_step;
  logic [31:0]                     rx_flex;
  logic [SUM_W-1:0]                sum_d;
  logic                            last_ent;
  logic                            rd_start;
  logic                            rd_done;
  logic [15:0]                     rd_ratio;
  logic [DIV_W-1:0]                div_val;
  logic                            hit;

  function automatic aupt_pkg::res_t mk_res(logic st, logic [7:0] fi, logic fv,
                                            logic ls, logic ent,
                                            aupt_pkg::row_t r, logic [15:0] ratio);
    aupt_pkg::res_t o;
    o.status            = st;
    o.found_index       = fi;
    o.found_valid       = fv;
    o.last              = ls;
    o.access_count      = ent ? r.acc  : 32'd0;
    o.update_count      = ent ? r.upd  : 32'd0;
    o.flexible_interval = ent ? r.flex : 32'd0;
    o.next_update_time  = ent ? r.due  : 48'd0;
    o.p_ext_ratio       = ratio;
    return o;
  endfunction

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && (state_q == ST_IDLE);

  // Request decode done at accept time.
  always_comb begin
    in_range = (32'(req_i.index) < 32'(TABLE_DEPTH));
    scan_end = 10'(req_i.index) + 10'(req_i.scan_count);
    maxf_eff = (req_i.max_found > 7'(MAX_FOUND)) ? 7'(MAX_FOUND) : req_i.max_found;
    tgt_prod = PW'(req_i.relax_fraction) * PW'(TABLE_DEPTH);
    tgt_raw  = tgt_prod >> 8;
    clr_cnt  = accept && (req_i.func == aupt_pkg::FUNC_CLR_ALL);
  end

  // Single-entry update of the row just read.
  always_comb begin
    sg_row = rdata;
    case (req_q.func)
      aupt_pkg::FUNC_ACC_INC: begin
        if (rdata.acc != 32'hFFFF_FFFF) begin
          sg_row.acc = rdata.acc + 32'd1;
        end
      end
      aupt_pkg::FUNC_ACC_CLR: sg_row.acc = 32'd0;
      aupt_pkg::FUNC_UPD_INC: begin
        if (rdata.upd != 32'hFFFF_FFFF) begin
          sg_row.upd = rdata.upd + 32'd1;
        end
      end
      aupt_pkg::FUNC_UPD_CLR: sg_row.upd = 32'd0;
      aupt_pkg::FUNC_SCHEDULE: sg_row.due = req_q.now_ms + 48'(rdata.flex >> 9);
      default: sg_row = rdata;
    endcase
  end

  // Relax datapath: candidate test, stretch bounds and running sum.
  always_comb begin
    cand       = (target_q != '0) && (rdata.acc < rdata.upd);
    d10_start  = (state_q == ST_RX_EX) && cand;
    hi_bound   = 36'(beta_q) * 36'(avi_q);
    stretch_ok = (d10_q >= 36'({avi_q, 8'd0})) && (d10_q <= hi_bound)
                 && (d10_q[35:32] == 4'd0);
    rx_step    = ((state_q == ST_RX_EX) && !cand) || ((state_q == ST_RX_DV) && d10_done);
    if (state_q == ST_RX_DV) begin
      rx_flex = stretch_ok ? d10_q[31:0] : row_q.flex;
    end else begin
      rx_flex = rdata.flex;
    end
    sum_d    = sum_q + SUM_W'(rx_flex);
    last_ent = (i_q == CW'(TABLE_DEPTH - 1));
    rd_start = rx_step && last_ent;
    div_val  = DIV_W'(avi_q) * DIV_W'(TABLE_DEPTH);
    hit      = (rdata.due <= req_q.now_ms);
  end

  // Memory write port.
  always_comb begin
    we    = 1'b0;
    wdata = sg_row;
    if (state_q == ST_CLR) begin
      we         = 1'b1;
      wdata      = '0;
      wdata.flex = init_flex_q;
    end else if (state_q == ST_SG_EX) begin
      we = 1'b1;
    end else if ((state_q == ST_RX_DV) && d10_done && stretch_ok) begin
      we        = 1'b1;
      wdata     = row_q;
      wdata.flex = d10_q[31:0];
    end
  end

  aupt_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (we),
    .addr_i      (i_q[AW-1:0]),
    .wdata_i     (wdata),
    .clr_cnt_i   (clr_cnt),
    .rdata_o     (rdata)
  );

  aupt_div10 u_div10 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (d10_start),
    .x_i     ({4'd0, rdata.flex} + {1'b0, rdata.flex, 3'd0} + {3'd0, rdata.flex, 1'b0}),
    .done_o  (d10_done),
    .q_o     (d10_q)
  );

  aupt_ratio_div #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W)
  ) u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rd_start),
    .sum_i   (sum_d),
    .div_i   (div_val),
    .done_o  (rd_done),
    .ratio_o (rd_ratio)
  );

  // Sequencer, configuration registers and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      avi_q       <= aupt_pkg::AVI_RESET;
      beta_q      <= aupt_pkg::BETA_RESET;
      init_flex_q <= {aupt_pkg::AVI_RESET, 8'd0};
      mean_q      <= aupt_pkg::RATIO_ONE;
      res_valid_o <= 1'b0;
      res_o       <= '0;
      req_q       <= '0;
      i_q         <= '0;
      end_q       <= '0;
      target_q    <= '0;
      maxf_q      <= '0;
      hits_q      <= '0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      sum_q       <= '0;
      row_q       <= '0;
      clr_res_q   <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;

      if (cfg_valid_i) begin
        if (cfg_index_i == aupt_pkg::CFG_AVI) begin
          avi_q <= cfg_data_i;
        end else if (cfg_index_i == aupt_pkg::CFG_BETA) begin
          beta_q <= cfg_data_i[aupt_pkg::BETA_W-1:0];
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            req_q <= req_i;
            case (req_i.func)
              aupt_pkg::FUNC_INIT: begin
                init_flex_q <= {avi_q, 8'd0};
                mean_q      <= aupt_pkg::RATIO_ONE;
                i_q         <= '0;
                clr_res_q   <= 1'b1;
                state_q     <= ST_CLR;
              end
              aupt_pkg::FUNC_ACC_INC, aupt_pkg::FUNC_ACC_CLR, aupt_pkg::FUNC_UPD_INC,
              aupt_pkg::FUNC_UPD_CLR, aupt_pkg::FUNC_SCHEDULE, aupt_pkg::FUNC_READ: begin
                if (in_range) begin
                  i_q     <= CW'(req_i.index);
                  state_q <= ST_SG_RD;
                end else begin
                  res_valid_o <= 1'b1;
                  res_o <= mk_res(aupt_pkg::STATUS_ERR, 8'd0, 1'b0, 1'b1, 1'b0, rdata,
                                  mean_q);
                end
              end
              aupt_pkg::FUNC_SCAN: begin
                if (32'(scan_end) > 32'(TABLE_DEPTH)) begin
                  res_valid_o <= 1'b1;
                  res_o <= mk_res(aupt_pkg::STATUS_ERR, 8'd0, 1'b0, 1'b1, 1'b0, rdata,
                                  mean_q);
                end else if ((maxf_eff == '0) || (req_i.scan_count == '0)) begin
                  res_valid_o <= 1'b1;
                  res_o <= mk_res(aupt_pkg::STATUS_OK, 8'd0, 1'b0, 1'b1, 1'b0, rdata,
                                  mean_q);
                end else begin
                  i_q     <= CW'(req_i.index);
                  end_q   <= CW'(scan_end);
                  maxf_q  <= maxf_eff;
                  hits_q  <= '0;
                  pend_q  <= 1'b0;
                  state_q <= ST_SC_RD;
                end
              end
              aupt_pkg::FUNC_RELAX: begin
                target_q <= (tgt_raw > PW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                         : CW'(tgt_raw);
                i_q      <= '0;
                sum_q    <= '0;
                state_q  <= ST_RX_RD;
              end
              default: begin
                // Clear-all and unused codes answer at once.
                res_valid_o <= 1'b1;
                res_o <= mk_res(aupt_pkg::STATUS_OK, 8'd0, 1'b0, 1'b1, 1'b0, rdata,
                                mean_q);
              end
            endcase
          end
        end

        // Clearing pass: one row per cycle; only an init answers at the end.
        ST_CLR: begin
          if (last_ent) begin
            if (clr_res_q) begin
              res_valid_o <= 1'b1;
              res_o <= mk_res(aupt_pkg::STATUS_OK, 8'd0, 1'b0, 1'b1, 1'b0, rdata,
                              mean_q);
            end
            clr_res_q <= 1'b0;
            state_q   <= ST_IDLE;
          end else begin
            i_q <= i_q + CW'(1);
          end
        end

        ST_SG_RD: state_q <= ST_SG_EX;

        ST_SG_EX: begin
          res_valid_o <= 1'b1;
          res_o <= mk_res(aupt_pkg::STATUS_OK, 8'd0, 1'b0, 1'b1, 1'b1, sg_row, mean_q);
          state_q <= ST_IDLE;
        end

        ST_SC_RD: state_q <= ST_SC_EX;

        // A hit is held back one step so that the final one can carry last.
        ST_SC_EX: begin
          if (hit) begin
            if (pend_q) begin
              res_valid_o <= 1'b1;
              res_o <= mk_res(aupt_pkg::STATUS_OK, pidx_q, 1'b1, 1'b0, 1'b0, rdata,
                              mean_q);
            end
            pend_q <= 1'b1;
            pidx_q <= 8'(i_q);
            hits_q <= hits_q + 7'd1;
          end
          if ((hit && (hits_q + 7'd1 == maxf_q)) || (i_q + CW'(1) == end_q)) begin
            state_q <= ST_SC_FIN;
          end else begin
            i_q     <= i_q + CW'(1);
            state_q <= ST_SC_RD;
          end
        end

        ST_SC_FIN: begin
          res_valid_o <= 1'b1;
          res_o <= mk_res(aupt_pkg::STATUS_OK, pend_q ? pidx_q : 8'd0, pend_q, 1'b1,
                          1'b0, rdata, mean_q);
          state_q <= ST_IDLE;
        end

        ST_RX_RD: state_q <= ST_RX_EX;

        ST_RX_EX: begin
          row_q <= rdata;
          if (cand) begin
            target_q <= target_q - CW'(1);
            state_q  <= ST_RX_DV;
          end
        end

        ST_RX_DV: ;

        ST_RX_MN: begin
          if (rd_done) begin
            mean_q      <= rd_ratio;
            res_valid_o <= 1'b1;
            res_o <= mk_res(aupt_pkg::STATUS_OK, 8'd0, 1'b0, 1'b1, 1'b0, rdata,
                            rd_ratio);
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase

      // Advance the relax walk once a row is settled.
      if (rx_step) begin
        sum_q <= sum_d;
        if (last_ent) begin
          state_q <= ST_RX_MN;
        end else begin
          i_q     <= i_q + CW'(1);
          state_q <= ST_RX_RD;
        end
      end
    end
  end

endmodule

// ----- bench/aupt_checker.sv -----
// Checker for the policy table: predicts every result and compares it with the block.
`timescale 1ns / 1ps

module aupt_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  aupt_pkg::req_t                  req_i,
  input  logic                            res_valid_i,
  input  aupt_pkg::res_t                  res_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [aupt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [aupt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  localparam int unsigned DEPTH = aupt_pkg::DEF_TABLE_DEPTH;

  // Shadow copy of the table and its registers.
  logic [aupt_pkg::AVI_W-1:0]  avi_q;
  logic [aupt_pkg::BETA_W-1:0] beta_q;
  logic [31:0]       acc_q [DEPTH];
  logic [31:0]       upd_q [DEPTH];
  logic [31:0]       flex_q [DEPTH];
  logic [47:0]       due_q [DEPTH];
  logic [15:0]       ratio_q;

  aupt_pkg::res_t expected_results[$];
  int   mismatches;

  assign pending_o    = expected_results.size();
  assign fail_count_o = mismatches;

  task automatic clear_table();
    for (int i = 0; i < DEPTH; i++) begin
      acc_q[i]  = '0;
      upd_q[i]  = '0;
      flex_q[i] = {avi_q, 8'd0};
      due_q[i]  = '0;
    end
    ratio_q = aupt_pkg::RATIO_ONE;
  endtask

  // Builds one result; entry < 0 leaves the entry fields zero.
  function automatic aupt_pkg::res_t make_result(logic status, logic [7:0] fidx,
                                                 logic fvalid, logic last, int entry);
    aupt_pkg::res_t r;
    r = '0;
    r.status      = status;
    r.found_index = fidx;
    r.found_valid = fvalid;
    r.last        = last;
    if (entry >= 0) begin
      r.access_count      = acc_q[entry];
      r.update_count      = upd_q[entry];
      r.flexible_interval = flex_q[entry];
      r.next_update_time  = due_q[entry];
    end
    r.p_ext_ratio = ratio_q;
    return r;
  endfunction

  // Stretches the intervals of cold rows and recomputes the mean ratio.
  task automatic relax_intervals(logic [8:0] fraction);
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] stretched;
    logic [63:0] sum;
    logic [63:0] divisor;
    logic [63:0] quotient;
    target = (64'(fraction) * DEPTH) >> 8;
    if (target > DEPTH) target = DEPTH;
    lo = 64'(avi_q) << 8;
    hi = 64'(beta_q) * 64'(avi_q);
    for (int i = 0; i < DEPTH && target > 0; i++) begin
      if (acc_q[i] < upd_q[i]) begin
        stretched = (64'(flex_q[i]) * 11) / 10;
        if (lo <= stretched && stretched <= hi && stretched <= 64'hFFFF_FFFF)
          flex_q[i] = stretched[31:0];
        target--;
      end
    end
    sum = '0;
    for (int i = 0; i < DEPTH; i++) sum += 64'(flex_q[i]);
    divisor = 64'(avi_q) * DEPTH;
    if (divisor == 0) begin
      ratio_q = aupt_pkg::RATIO_MAX;
    end else begin
      quotient = sum / divisor;
      ratio_q  = (quotient > 64'hFFFF) ? aupt_pkg::RATIO_MAX : quotient[15:0];
    end
  endtask

  // Applies one request to the shadow table and queues the results it causes.
  task automatic predict_results(aupt_pkg::req_t r);
    int          hits;
    int          hit_rows[$];
    logic [9:0]  range_end;
    int          limit;
    case (r.func)
      aupt_pkg::FUNC_INIT: begin
        clear_table();
        expected_results.push_back(make_result(aupt_pkg::STATUS_OK, '0, 1'b0, 1'b1, -1));
      end
      aupt_pkg::FUNC_CLR_ALL: begin
        for (int i = 0; i < DEPTH; i++) begin
          acc_q[i] = '0;
          upd_q[i] = '0;
        end
        expected_results.push_back(make_result(aupt_pkg::STATUS_OK, '0, 1'b0, 1'b1, -1));
      end
      aupt_pkg::FUNC_RELAX: begin
        relax_intervals(r.relax_fraction);
        expected_results.push_back(make_result(aupt_pkg::STATUS_OK, '0, 1'b0, 1'b1, -1));
      end
      aupt_pkg::FUNC_SCAN: begin
        range_end = 10'(r.index) + 10'(r.scan_count);
        limit = (r.max_found > aupt_pkg::DEF_MAX_FOUND) ? int'(aupt_pkg::DEF_MAX_FOUND)
                                                        : int'(r.max_found);
        if (range_end > DEPTH) begin
          expected_results.push_back(make_result(aupt_pkg::STATUS_ERR, '0, 1'b0, 1'b1,
                                                 -1));
        end else begin
          hits = 0;
          for (int i = r.index; i < range_end && hits < limit; i++) begin
            if (due_q[i] <= r.now_ms) begin
              hit_rows.push_back(i);
              hits++;
            end
          end
          if (hits == 0) begin
            expected_results.push_back(make_result(aupt_pkg::STATUS_OK, '0, 1'b0, 1'b1,
                                                   -1));
          end else begin
            for (int k = 0; k < hits; k++)
              expected_results.push_back(make_result(aupt_pkg::STATUS_OK,
                                                     8'(hit_rows[k]), 1'b1,
                                                     k == hits - 1, -1));
          end
        end
      end
      aupt_pkg::FUNC_ACC_INC, aupt_pkg::FUNC_ACC_CLR, aupt_pkg::FUNC_UPD_INC,
      aupt_pkg::FUNC_UPD_CLR, aupt_pkg::FUNC_SCHEDULE, aupt_pkg::FUNC_READ: begin
        // The 8-bit index always lies inside a 256-row table.
        case (r.func)
          aupt_pkg::FUNC_ACC_INC: if (acc_q[r.index] != '1) acc_q[r.index]++;
          aupt_pkg::FUNC_ACC_CLR: acc_q[r.index] = '0;
          aupt_pkg::FUNC_UPD_INC: if (upd_q[r.index] != '1) upd_q[r.index]++;
          aupt_pkg::FUNC_UPD_CLR: upd_q[r.index] = '0;
          aupt_pkg::FUNC_SCHEDULE: due_q[r.index] = r.now_ms + 48'(flex_q[r.index] >> 9);
          default: ;
        endcase
        expected_results.push_back(make_result(aupt_pkg::STATUS_OK, '0, 1'b0, 1'b1,
                                               int'(r.index)));
      end
      default: begin
        expected_results.push_back(make_result(aupt_pkg::STATUS_OK, '0, 1'b0, 1'b1, -1));
      end
    endcase
  endtask

  // Compares one result with the oldest expectation.
  task automatic check_result(aupt_pkg::res_t got);
    aupt_pkg::res_t exp;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: result with nothing expected: %p", $realtime, got);
    end else begin
      exp = expected_results.pop_front();
      if (got.status !== exp.status || got.found_index !== exp.found_index ||
          got.found_valid !== exp.found_valid || got.last !== exp.last ||
          got.access_count !== exp.access_count || got.update_count !== exp.update_count ||
          got.flexible_interval !== exp.flexible_interval ||
          got.next_update_time !== exp.next_update_time ||
          got.p_ext_ratio !== exp.p_ext_ratio) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected %p", exp);
          $display("  actual   %p", got);
        end
      end
    end
  endtask

  // Results are checked before a new request is predicted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avi_q  = aupt_pkg::AVI_RESET;
      beta_q = aupt_pkg::BETA_RESET;
      clear_table();
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (res_valid_i) check_result(res_i);
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == aupt_pkg::CFG_AVI) avi_q = cfg_data_i[aupt_pkg::AVI_W-1:0];
        else if (cfg_index_i == aupt_pkg::CFG_BETA) beta_q = cfg_data_i[aupt_pkg::BETA_W-1:0];
      end
      if (start_i && !busy_i) predict_results(req_i);
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Stimulus and verdict for the adaptive update policy table.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int PHASE_ITEMS    = 100;
  localparam int REQ_W          = $bits(aupt_pkg::req_t);

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  aupt_pkg::req_t                  req;
  logic                            res_valid;
  aupt_pkg::res_t                  res;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [aupt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [aupt_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              fail_count;
  int                              pending;
  int                              idle_cycles;
  logic [47:0]                     clock_ms;
  logic                            gaps_on;

  adaptive_update_policy_table DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  aupt_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog: counts cycles without any transfer on any channel.
  always @(posedge clk) begin
    if ((start && !busy) || res_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic aupt_pkg::req_t make_req(logic [3:0] func, logic [7:0] idx,
                                              logic [8:0] cnt, logic [6:0] maxf,
                                              logic [47:0] now, logic [8:0] frac);
    aupt_pkg::req_t r;
    r.func           = func;
    r.index          = idx;
    r.scan_count     = cnt;
    r.max_found      = maxf;
    r.now_ms         = now;
    r.relax_fraction = frac;
    return r;
  endfunction

  // Random request: mostly operations on a small hot set of rows so that
  // counts build up, schedules and scans meet, and relax has work to do.
  function automatic aupt_pkg::req_t random_req(logic [47:0] base_ms);
    aupt_pkg::req_t r;
    int   pick;
    r = REQ_W'({$urandom, $urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 25)      r.func = aupt_pkg::FUNC_UPD_INC;
    else if (pick < 40) r.func = aupt_pkg::FUNC_ACC_INC;
    else if (pick < 52) r.func = aupt_pkg::FUNC_SCHEDULE;
    else if (pick < 66) r.func = aupt_pkg::FUNC_SCAN;
    else if (pick < 76) r.func = aupt_pkg::FUNC_READ;
    else if (pick < 82) r.func = aupt_pkg::FUNC_RELAX;
    else if (pick < 87) r.func = aupt_pkg::FUNC_ACC_CLR;
    else if (pick < 91) r.func = aupt_pkg::FUNC_UPD_CLR;
    else if (pick < 93) r.func = aupt_pkg::FUNC_CLR_ALL;
    else if (pick < 94) r.func = aupt_pkg::FUNC_INIT;
    else if (pick < 97) r.func = 4'($urandom_range(10, 15));
    else                r.func = 4'($urandom);
    if ($urandom_range(0, 3) != 0) r.index = 8'($urandom_range(0, 15));
    if ($urandom_range(0, 4) != 0) begin
      r.scan_count = 9'($urandom_range(1, 40));
      if (32'(r.index) + r.scan_count > 256) r.scan_count = 9'(256 - r.index);
    end
    if ($urandom_range(0, 2) != 0) r.max_found = 7'($urandom_range(1, 8));
    if ($urandom_range(0, 4) != 0) r.now_ms = base_ms + 48'($urandom_range(0, 4000));
    return r;
  endfunction

  // Offers one request after a random gap; start stays high when the gap is zero.
  task automatic send_req(aupt_pkg::req_t r);
    int gap;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    req   = r;
    do @(posedge clk); while (busy);
  endtask

  // Holds the sender off until every expected result has arrived.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [aupt_pkg::CFG_IDX_W-1:0] idx,
                           logic [aupt_pkg::CFG_DATA_W-1:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_phase(int n);
    gaps_on = $urandom_range(0, 3) != 0;
    for (int i = 0; i < n; i++) begin
      // Time mostly moves forward so due rows expire over the run.
      clock_ms = clock_ms + 48'($urandom_range(0, 300));
      send_req(random_req(clock_ms));
      if (i == n / 2) gaps_on = !gaps_on;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    req         = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    idle_cycles = 0;
    clock_ms    = '0;
    gaps_on     = 1'b1;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: field extremes, every operation and the corner cases.
    send_req(make_req(aupt_pkg::FUNC_READ, 8'd0, '0, '0, '0, '0));
    send_req(make_req(aupt_pkg::FUNC_READ, 8'd255, '1, '1, '1, '1));
    send_req(make_req(aupt_pkg::FUNC_ACC_INC, 8'd255, '0, '0, '0, '0));
    send_req(make_req(aupt_pkg::FUNC_UPD_INC, 8'd0, '0, '0, '0, '0));
    send_req(make_req(aupt_pkg::FUNC_UPD_INC, 8'd0, '0, '0, '0, '0));
    send_req(make_req(aupt_pkg::FUNC_UPD_INC, 8'd255, '0, '0, '0, '0));
    send_req(make_req(aupt_pkg::FUNC_RELAX, 8'd0, '0, '0, '0, 9'd256));
    send_req(make_req(aupt_pkg::FUNC_RELAX, 8'd0, '0, '0, '0, 9'd511));
    send_req(make_req(aupt_pkg::FUNC_RELAX, 8'd0, '0, '0, '0, 9'd0));
    send_req(make_req(aupt_pkg::FUNC_SCHEDULE, 8'd0, '0, '0, '1, '0));
    send_req(make_req(aupt_pkg::FUNC_SCHEDULE, 8'd255, '0, '0, 48'd0, '0));
    send_req(make_req(aupt_pkg::FUNC_SCAN, 8'd0, 9'd256, 7'd127, '1, '0));
    send_req(make_req(aupt_pkg::FUNC_SCAN, 8'd255, 9'd2, 7'd4, '1, '0));
    send_req(make_req(aupt_pkg::FUNC_SCAN, 8'd10, 9'd0, 7'd4, '1, '0));
    send_req(make_req(aupt_pkg::FUNC_SCAN, 8'd0, 9'd8, 7'd0, '1, '0));
    send_req(make_req(aupt_pkg::FUNC_SCAN, 8'd0, 9'd511, 7'd1, '0, '0));
    send_req(make_req(aupt_pkg::FUNC_SCAN, 8'd1, 9'd3, 7'd64, 48'd0, '0));
    send_req(make_req(4'd10, 8'd3, '0, '0, '0, '0));
    send_req(make_req(4'd15, 8'd3, '0, '0, '0, '0));
    send_req(make_req(aupt_pkg::FUNC_ACC_CLR, 8'd255, '0, '0, '0, '0));
    send_req(make_req(aupt_pkg::FUNC_UPD_CLR, 8'd0, '0, '0, '0, '0));
    send_req(make_req(aupt_pkg::FUNC_CLR_ALL, 8'd0, '0, '0, '0, '0));
    send_req(make_req(aupt_pkg::FUNC_INIT, 8'd0, '0, '0, '0, '0));

    // Random phases, each under its own register setting.
    random_phase(PHASE_ITEMS);

    write_reg(aupt_pkg::CFG_AVI, 24'd1);
    write_reg(aupt_pkg::CFG_BETA, 24'd4095);
    send_req(make_req(aupt_pkg::FUNC_INIT, '0, '0, '0, '0, '0));
    random_phase(PHASE_ITEMS);

    // Largest interval and tightest bound, without a re-init first.
    write_reg(aupt_pkg::CFG_AVI, 24'hFF_FFFF);
    write_reg(aupt_pkg::CFG_BETA, 24'd1);
    random_phase(PHASE_ITEMS / 2);
    send_req(make_req(aupt_pkg::FUNC_INIT, '0, '0, '0, '0, '0));
    random_phase(PHASE_ITEMS / 2);

    // A zero interval drives the ratio to its ceiling on relax.
    write_reg(aupt_pkg::CFG_AVI, 24'd0);
    write_reg(aupt_pkg::CFG_BETA, 24'd256);
    send_req(make_req(aupt_pkg::FUNC_RELAX, '0, '0, '0, '0, 9'd128));
    send_req(make_req(aupt_pkg::FUNC_READ, 8'd5, '0, '0, '0, '0));
    send_req(make_req(aupt_pkg::FUNC_INIT, '0, '0, '0, '0, '0));
    send_req(make_req(aupt_pkg::FUNC_RELAX, '0, '0, '0, '0, 9'd256));

    write_reg(aupt_pkg::CFG_AVI, 24'($urandom_range(1, 5000)));
    write_reg(aupt_pkg::CFG_BETA, 24'($urandom_range(256, 4095)));
    send_req(make_req(aupt_pkg::FUNC_INIT, '0, '0, '0, '0, '0));
    random_phase(PHASE_ITEMS);

    write_reg(aupt_pkg::CFG_AVI, 24'($urandom));
    write_reg(aupt_pkg::CFG_BETA, 24'($urandom));
    random_phase(PHASE_ITEMS);

    // Let the last results arrive, then allow for the block's tail.
    drain();
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/aupt_pkg.sv
rtl/aupt_mem.sv
rtl/aupt_div10.sv
rtl/aupt_ratio_div.sv
rtl/adaptive_update_policy_table.sv
bench/aupt_checker.sv
bench/tb_top.sv
